// ===== sv/assert_macros.svh =====
// ------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file rse_checker.sv.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre |-> post, same edge
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// pre |=> post, next edge
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/rse_pkg.sv =====
// ------------------------------------------------------------------------
// rse_pkg
// Shared constants, codes, types and helpers of the RPN stack evaluator.
// ------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// quotient bits produced by the divider; higher bits only mean saturation
	localparam int DIV_STEPS   = DATA_W + 1;

	// token codes
	localparam logic [2:0] OP_PUSH    = 3'd0;
	localparam logic [2:0] OP_ADD     = 3'd1;
	localparam logic [2:0] OP_SUB     = 3'd2;
	localparam logic [2:0] OP_MUL     = 3'd3;
	localparam logic [2:0] OP_DIV     = 3'd4;
	localparam logic [2:0] OP_UNKNOWN = 3'd5;
	localparam logic [2:0] OP_FINISH  = 3'd6;

	// status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_ZERO_DIV = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_EMPTY    = 3'd3;
	localparam logic [2:0] STAT_UNKNOWN  = 3'd4;
	localparam logic [2:0] STAT_IGNORED  = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_FIN,
		ST_RD_B,
		ST_RD_A,
		ST_EXEC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                     start;
		logic [2:0]               op;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} arith_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] value;
	} arith_rsp_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi_lim;
		logic signed [63:0] lo_lim;
		hi_lim = 64'sd2147483647;
		lo_lim = -64'sd2147483648;
		if (v > hi_lim) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo_lim) begin
			return 32'sh8000_0000;
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/rse_stack_mem.sv =====
// ------------------------------------------------------------------------
// rse_stack_mem
// Operand stack storage: one write port, one read port, registered read.
// ------------------------------------------------------------------------
`default_nettype none

module rse_stack_mem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [rse_pkg::ADDR_W-1:0]   waddr,
	input  logic [rse_pkg::DATA_W-1:0]   wdata,
	input  logic                         re,
	input  logic [rse_pkg::ADDR_W-1:0]   raddr,
	output logic [rse_pkg::DATA_W-1:0]   rdata
);
	import rse_pkg::*;

	logic [DATA_W-1:0] mem_q [STACK_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/rse_div.sv =====
// ------------------------------------------------------------------------
// rse_div
// Signed fixed-point divider, one quotient bit per cycle (restoring).
// ------------------------------------------------------------------------
`default_nettype none

module rse_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [rse_pkg::DATA_W-1:0]  a,
	input  logic signed [rse_pkg::DATA_W-1:0]  b,
	output logic                               done,
	output logic signed [rse_pkg::DATA_W-1:0]  q
);
	import rse_pkg::*;

	localparam int DVW = FRAC_BITS + DIV_STEPS;
	localparam int CW  = $clog2(DIV_STEPS + 1);
	localparam logic [DIV_STEPS-1:0] POS_LIM = DIV_STEPS'(33'h0_7FFF_FFFF);
	localparam logic [DIV_STEPS-1:0] NEG_LIM = DIV_STEPS'(33'h0_8000_0000);

	logic [DATA_W-1:0]    mag_a, mag_b;
	logic [DVW-1:0]       dvd, hi;
	logic                 ovf_c;
	logic [DATA_W:0]      trial, diff;
	logic                 ge;
	logic [DIV_STEPS-1:0] neg_quo;
	logic signed [DATA_W-1:0] q_c;

	logic                 busy_q, fin_q, done_q;
	logic [CW-1:0]        cnt_q;
	logic [DATA_W-1:0]    rem_q, magb_q;
	logic [DIV_STEPS-1:0] lo_q, quo_q;
	logic                 neg_q, ovf_q;
	logic signed [DATA_W-1:0] q_q;

	always_comb begin
		mag_a = a[DATA_W-1] ? (~a + 32'd1) : a;
		mag_b = b[DATA_W-1] ? (~b + 32'd1) : b;
		dvd   = DVW'(mag_a) << FRAC_BITS;
		hi    = dvd >> DIV_STEPS;
		// quotient would need more than DIV_STEPS bits: saturates anyway
		ovf_c = hi >= DVW'(mag_b);
	end

	always_comb begin
		trial = {rem_q, lo_q[DIV_STEPS-1]};
		diff  = trial - {1'b0, magb_q};
		ge    = trial >= {1'b0, magb_q};
	end

	always_comb begin
		neg_quo = ~quo_q + DIV_STEPS'(1);
		if (neg_q) begin
			q_c = (ovf_q || quo_q > NEG_LIM) ? 32'sh8000_0000 : neg_quo[DATA_W-1:0];
		end else begin
			q_c = (ovf_q || quo_q > POS_LIM) ? 32'sh7FFF_FFFF : quo_q[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !ovf_c;
				fin_q  <= ovf_c;
				cnt_q  <= CW'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= hi[DATA_W-1:0];
			lo_q   <= dvd[DIV_STEPS-1:0];
			quo_q  <= '0;
			magb_q <= mag_b;
			neg_q  <= a[DATA_W-1] ^ b[DATA_W-1];
			ovf_q  <= ovf_c;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
			lo_q  <= lo_q << 1;
		end
		if (fin_q) begin
			q_q <= q_c;
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

`default_nettype wire

// ===== sv/rse_arith.sv =====
// ------------------------------------------------------------------------
// rse_arith
// Saturating Q16.16 add, subtract, multiply and divide with start/done.
// ------------------------------------------------------------------------
`default_nettype none

module rse_arith (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rse_pkg::arith_req_t  req,
	output rse_pkg::arith_rsp_t  rsp
);
	import rse_pkg::*;

	logic signed [DATA_W:0]   sum_c;
	logic signed [63:0]       prod_c;
	logic                     div_start, div_done;
	logic signed [DATA_W-1:0] div_q;
	logic                     addsub_c;

	logic                     mul_v_s1, done_q;
	logic signed [63:0]       prod_s1;
	logic signed [DATA_W-1:0] res_q;

	always_comb begin
		addsub_c = req.start && (req.op == OP_ADD || req.op == OP_SUB);
		if (req.op == OP_SUB) begin
			sum_c = {req.a[DATA_W-1], req.a} - {req.b[DATA_W-1], req.b};
		end else begin
			sum_c = {req.a[DATA_W-1], req.a} + {req.b[DATA_W-1], req.b};
		end
		prod_c    = req.a * req.b;
		div_start = req.start && req.op == OP_DIV;
	end

	rse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (req.a),
		.b      (req.b),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			mul_v_s1 <= req.start && req.op == OP_MUL;
			done_q   <= addsub_c || mul_v_s1 || div_done;
		end
	end

	// arithmetic shift of the product rounds toward minus infinity
	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		if (addsub_c) begin
			res_q <= sat32(64'(sum_c));
		end else if (mul_v_s1) begin
			res_q <= sat32(prod_s1 >>> FRAC_BITS);
		end else if (div_done) begin
			res_q <= div_q;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

`default_nettype wire

// ===== sv/rpn_stack_evaluator_top.sv =====
// ------------------------------------------------------------------------
// rpn_stack_evaluator_top: RPN evaluator over a 128-entry Q16.16 stack.
// Push, unknown, ignored and empty finish tokens go from accept straight to the
// output state; a finish on a non-empty stack pops first; arithmetic tokens read
// both operands and wait for rse_arith, a zero divisor skipping it. Divide uses
// the 33-step shift-subtract divider. One token in flight. The next token is taken
// the cycle after its result enters the output register. Reset clears count,
// abort flag and control; stack RAM is not cleared.
// ------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// token channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         op,
	input  logic signed [rse_pkg::DATA_W-1:0]  operand_value,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic signed [rse_pkg::DATA_W-1:0]  result_value,
	output logic                               is_final
);
	import rse_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q, cnt_m1;
	logic             aborted_q;
	logic [2:0]       op_q;
	logic             empty_q;    // some pop of this token hit an empty stack
	logic             rd_hit_q;   // RAM read data belongs to a real pop
	logic signed [DATA_W-1:0] b_q;

	// pending result, waiting for the output register
	logic [2:0]               res_status_q;
	logic signed [DATA_W-1:0] res_value_q;
	logic                     res_fin_q;

	// output register
	logic                     out_valid_q;
	logic [2:0]               status_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     fin_q;

	// stack RAM port
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	arith_req_t arith_req;
	arith_rsp_t arith_rsp;

	// control strobes from the output decoder
	logic                     cnt_inc, cnt_dec;
	logic                     set_abort, clr_abort;
	logic                     res_load;
	logic [2:0]               res_status_d;
	logic signed [DATA_W-1:0] res_value_d;
	logic                     res_fin_d;

	logic                     accept, cnt_nz, cnt_full, div_zero, out_free;
	logic signed [DATA_W-1:0] pop_val;
	logic                     is_arith_op;

	always_comb begin
		accept      = in_valid && state_q == ST_IDLE;
		cnt_nz      = cnt_q != '0;
		cnt_full    = cnt_q == CNT_W'(STACK_DEPTH);
		cnt_m1      = cnt_q - CNT_W'(1);
		// an empty pop reads zero
		pop_val     = rd_hit_q ? mem_rdata : '0;
		div_zero    = op_q == OP_DIV && pop_val == '0;
		out_free    = !out_valid_q || !out_stall;
		is_arith_op = op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
	end

	rse_stack_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rse_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (arith_req),
		.rsp    (arith_rsp)
	);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (op == OP_FINISH && cnt_nz) begin
						state_d = ST_POP_FIN;
					end else if (op != OP_FINISH && !aborted_q && is_arith_op) begin
						state_d = ST_RD_B;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_POP_FIN: state_d = ST_OUT;
			ST_RD_B:    state_d = div_zero ? ST_OUT : ST_RD_A;
			ST_RD_A:    state_d = ST_EXEC;
			ST_EXEC: begin
				if (arith_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- control outputs ----------------
	// The RAM is touched by one token at a time: a write (push) always lands
	// before the next read, so no forwarding is needed.
	always_comb begin
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		set_abort    = 1'b0;
		clr_abort    = 1'b0;
		res_load     = 1'b0;
		res_status_d = STAT_OK;
		res_value_d  = '0;
		res_fin_d    = 1'b0;
		mem_wdata    = arith_rsp.value;
		mem_waddr    = cnt_q[ADDR_W-1:0];
		mem_raddr    = cnt_m1[ADDR_W-1:0];
		in_stall     = state_q != ST_IDLE;
		arith_req.start = 1'b0;
		arith_req.op    = op_q;
		arith_req.a     = pop_val;
		arith_req.b     = b_q;
		case (state_q)
			ST_IDLE: begin
				mem_wdata = operand_value;
				if (in_valid) begin
					if (op == OP_FINISH) begin
						clr_abort = 1'b1;
						if (cnt_nz) begin
							mem_re  = 1'b1;
							cnt_dec = 1'b1;
						end else begin
							res_load     = 1'b1;
							res_status_d = STAT_EMPTY;
							res_fin_d    = 1'b1;
						end
					end else if (aborted_q) begin
						res_load     = 1'b1;
						res_status_d = STAT_IGNORED;
					end else if (op == OP_PUSH) begin
						res_load = 1'b1;
						if (!cnt_full) begin
							mem_we      = 1'b1;
							cnt_inc     = 1'b1;
							res_value_d = operand_value;
						end else begin
							res_status_d = STAT_FULL;
						end
					end else if (is_arith_op) begin
						// pop divisor / right operand
						if (cnt_nz) begin
							mem_re  = 1'b1;
							cnt_dec = 1'b1;
						end
					end else begin
						set_abort    = 1'b1;
						res_load     = 1'b1;
						res_status_d = STAT_UNKNOWN;
					end
				end
			end
			ST_POP_FIN: begin
				res_load    = 1'b1;
				res_value_d = pop_val;
				res_fin_d   = 1'b1;
			end
			ST_RD_B: begin
				if (div_zero) begin
					// divisor is dropped, dividend stays
					res_load     = 1'b1;
					res_status_d = empty_q ? STAT_EMPTY : STAT_ZERO_DIV;
				end else if (cnt_nz) begin
					mem_re  = 1'b1;
					cnt_dec = 1'b1;
				end
			end
			ST_RD_A: begin
				arith_req.start = 1'b1;
			end
			ST_EXEC: begin
				// after a pop there is always room for the push
				if (arith_rsp.done) begin
					mem_we       = 1'b1;
					cnt_inc      = 1'b1;
					res_load     = 1'b1;
					res_value_d  = arith_rsp.value;
					res_status_d = empty_q ? STAT_EMPTY : STAT_OK;
				end
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			aborted_q   <= 1'b0;
			rd_hit_q    <= 1'b0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_hit_q <= mem_re;
			if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (set_abort) begin
				aborted_q <= 1'b1;
			end else if (clr_abort) begin
				aborted_q <= 1'b0;
			end
			if (accept) begin
				empty_q <= !cnt_nz;
			end else if (state_q == ST_RD_B && !div_zero && !cnt_nz) begin
				empty_q <= 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
		end
		if (state_q == ST_RD_B) begin
			b_q <= pop_val;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_value_q  <= res_value_d;
			res_fin_q    <= res_fin_d;
		end
		if (state_q == ST_OUT && out_free) begin
			status_q <= res_status_q;
			value_q  <= res_value_q;
			fin_q    <= res_fin_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = value_q;
	assign is_final     = fin_q;

endmodule

`default_nettype wire

// ===== sv/rse_checker.sv =====
// ------------------------------------------------------------------------
// rse_checker
// Port-level checks of the RPN stack evaluator, bound to the top level.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rse_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [2:0]                        status,
	input logic signed [rse_pkg::DATA_W-1:0] result_value,
	input logic                              is_final
);
	import rse_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(result_value) && $stable(is_final), "stalled result beat changed")

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "token accepted while another is in flight")

	`ASSERT_IMPL(a_final_status, clk, arst_n, out_valid && is_final, status == STAT_OK || status == STAT_EMPTY, "finish beat with bad status")

	`ASSERT_IMPL(a_error_zero, clk, arst_n, out_valid && !is_final && (status == STAT_ZERO_DIV || status == STAT_FULL || status == STAT_UNKNOWN || status == STAT_IGNORED), result_value == '0, "error beat carries a value")

endmodule

bind rpn_stack_evaluator_top rse_checker u_rse_checker (.*);

`default_nettype wire

// ===== tb/rpn_stack_evaluator_top_tb.sv =====
// ------------------------------------------------------------------------
// rpn_stack_evaluator_top_tb
// Self-checking bench for the RPN stack evaluator. A scoreboard class
// keeps its own copy of the operand stack and abort flag, predicts the
// result beat of every accepted token, and compares each result beat
// field by field. Stimulus: directed corner tokens, then random
// expressions, abort runs, noise and a full-stack fill, over phases of
// sender idling, receiver stalling and long receiver hold-offs.
// ------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator_top_tb;
	import rse_pkg::*;

	// spare op code, taken as an unknown command
	localparam logic [2:0] OP_UNKNOWN_ALT = 3'd7;

	// one expected result beat
	typedef struct packed {
		logic [2:0]               status;
		logic signed [DATA_W-1:0] value;
		logic                     fin;
	} rpn_result_t;

	// --------------------------------------------------------------------
	// Scoreboard: stack predictor plus queue of expected result beats
	// --------------------------------------------------------------------
	class rpn_scoreboard;
		logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];
		int                       depth_used;
		bit                       halted;      // unknown command seen, waiting for finish
		bit                       underflow;   // set by a pop from an empty stack
		rpn_result_t              expected_results [$];
		int                       errors;

		function new();
			depth_used = 0;
			halted = 1'b0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("ERROR @%0t: %s", $realtime, msg);
			end
		endtask

		function logic signed [DATA_W-1:0] clamp_q32(longint v);
			if (v > longint'(32'sh7FFF_FFFF)) begin
				return 32'sh7FFF_FFFF;
			end
			if (v < longint'(32'sh8000_0000)) begin
				return 32'sh8000_0000;
			end
			return v[DATA_W-1:0];
		endfunction

		// empty stack reads as zero and flags underflow
		function logic signed [DATA_W-1:0] pull();
			if (depth_used > 0) begin
				depth_used--;
				return stack_mem[depth_used];
			end
			underflow = 1'b1;
			return '0;
		endfunction

		function bit place(logic signed [DATA_W-1:0] v);
			if (depth_used < STACK_DEPTH) begin
				stack_mem[depth_used] = v;
				depth_used++;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// called once per accepted token beat
		function void note_token(logic [2:0] t_op, logic signed [DATA_W-1:0] t_val);
			rpn_result_t              r;
			logic signed [DATA_W-1:0] lhs;
			logic signed [DATA_W-1:0] rhs;
			logic signed [DATA_W-1:0] res;
			bit                       store;
			r.status = STAT_OK;
			r.value = '0;
			r.fin = 1'b0;
			underflow = 1'b0;
			store = 1'b1;
			res = '0;
			if (t_op == OP_FINISH) begin
				r.value = pull();
				r.fin = 1'b1;
				halted = 1'b0;
				if (underflow) begin
					r.status = STAT_EMPTY;
				end
			end else if (halted) begin
				r.status = STAT_IGNORED;
			end else if (t_op == OP_PUSH) begin
				if (place(t_val)) begin
					r.value = t_val;
				end else begin
					r.status = STAT_FULL;
				end
			end else if (t_op >= OP_ADD && t_op <= OP_DIV) begin
				rhs = pull();
				// zero divisor: divisor gone, dividend stays, nothing pushed
				if (t_op == OP_DIV && rhs == 0) begin
					store = 1'b0;
				end else begin
					lhs = pull();
					case (t_op)
						OP_ADD: res = clamp_q32(longint'(lhs) + longint'(rhs));
						OP_SUB: res = clamp_q32(longint'(lhs) - longint'(rhs));
						// arithmetic shift floors toward minus infinity
						OP_MUL: res = clamp_q32((longint'(lhs) * longint'(rhs)) >>> FRAC_BITS);
						// signed divide truncates toward zero
						default: res = clamp_q32((longint'(lhs) <<< FRAC_BITS) / longint'(rhs));
					endcase
				end
				// empty wins over zero divisor
				if (underflow) begin
					r.status = STAT_EMPTY;
				end else if (!store) begin
					r.status = STAT_ZERO_DIV;
				end
				if (store) begin
					if (place(res)) begin
						r.value = res;
					end else if (r.status == STAT_OK) begin
						r.status = STAT_FULL;
					end
				end
			end else begin
				// unknown command, spare op code included
				halted = 1'b1;
				r.status = STAT_UNKNOWN;
			end
			expected_results.push_back(r);
		endfunction

		// called once per accepted result beat
		task check_result(logic [2:0] s, logic signed [DATA_W-1:0] v, logic f);
			rpn_result_t e;
			if (expected_results.size() == 0) begin
				report($sformatf("result beat with nothing expected: status %0d value %h",
					s, v));
			end else begin
				e = expected_results.pop_front();
				if (s !== e.status) begin
					report($sformatf("status %0d, expected %0d", s, e.status));
				end
				if (v !== e.value) begin
					report($sformatf("result_value %h, expected %h", v, e.value));
				end
				if (f !== e.fin) begin
					report($sformatf("is_final %b, expected %b", f, e.fin));
				end
			end
		endtask
	endclass

	// --------------------------------------------------------------------
	// DUT signals; every input known from time 0
	// --------------------------------------------------------------------
	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [2:0]               op = OP_PUSH;
	logic signed [DATA_W-1:0] operand_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [2:0]               status;
	logic signed [DATA_W-1:0] result_value;
	logic                     is_final;

	rpn_scoreboard rpn_board = new();

	int send_idle_pct = 0;   // chance per cycle the sender sits out
	int stall_pct     = 0;   // chance per cycle the receiver stalls
	int hold_left     = 0;   // long receiver hold-off, counted down below
	int tokens_sent   = 0;

	rpn_stack_evaluator_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.result_value  (result_value),
		.is_final      (is_final)
	);

	// 4-unit clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// hard stop if the run hangs
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stall, or a long hold-off when one is armed
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// result monitor: sampled values are the ones before this edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			rpn_board.check_result(status, result_value, is_final);
		end
	end

	// --------------------------------------------------------------------
	// Token driver
	// --------------------------------------------------------------------
	// Returns at the edge that accepted the beat; valid stays high so a
	// back-to-back token needs no low/high pair in one step.
	task automatic send_token(input logic [2:0] t_op, input logic signed [DATA_W-1:0] t_val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= t_op;
		operand_value <= t_val;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		rpn_board.note_token(t_op, t_val);
		tokens_sent++;
	endtask

	// drop valid and wait out every expected result beat
	task automatic drain_results();
		in_valid <= 1'b0;
		while (rpn_board.expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// operand mix: mostly modest Q16.16 numbers, some raw and corner values
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0, 1: begin
				case ($urandom_range(6))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh0001_0000;
					3: return 32'shFFFF_0000;
					4: return 32'shFFFF_FFFF;
					5: return 32'sh0000_0001;
					default: return '0;
				endcase
			end
			2, 3: return $urandom;
			default: return $urandom_range(128 << FRAC_BITS) - (64 << FRAC_BITS);
		endcase
	endfunction

	function automatic logic [2:0] pick_arith();
		case ($urandom_range(3))
			0: return OP_ADD;
			1: return OP_SUB;
			2: return OP_MUL;
			default: return OP_DIV;
		endcase
	endfunction

	// well-formed expression of n operands on top of whatever is stacked
	task automatic send_expression(input int n);
		int pushed;
		int live;
		pushed = 0;
		live = 0;
		while (pushed < n || live > 1) begin
			if (pushed < n && (live < 2 || $urandom_range(1))) begin
				send_token(OP_PUSH, pick_value());
				pushed++;
				live++;
			end else begin
				send_token(pick_arith(), pick_value());
				live--;
			end
		end
		send_token(OP_FINISH, pick_value());
	endtask

	// unknown command, a few ignored tokens, then finish
	task automatic send_aborted_run();
		int n;
		logic [2:0] t;
		n = $urandom_range(5);
		send_token($urandom_range(1) ? OP_UNKNOWN : OP_UNKNOWN_ALT, pick_value());
		repeat (n) begin
			t = 3'($urandom_range(7));
			if (t == OP_FINISH) begin
				t = OP_PUSH;
			end
			send_token(t, pick_value());
		end
		send_token(OP_FINISH, pick_value());
	endtask

	// push past the top of the stack, then pop it dry and once more
	task automatic fill_and_drain();
		// a pending abort would swallow the pushes
		if (rpn_board.halted) begin
			send_token(OP_FINISH, pick_value());
		end
		while (rpn_board.depth_used < STACK_DEPTH) begin
			send_token(OP_PUSH, pick_value());
		end
		repeat (3) begin
			send_token(OP_PUSH, pick_value());
		end
		send_token(OP_ADD, pick_value());
		while (rpn_board.depth_used > 0) begin
			send_token(OP_FINISH, pick_value());
		end
		send_token(OP_FINISH, pick_value());
	endtask

	task automatic send_random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 62) begin
			send_expression($urandom_range(9) == 0 ? $urandom_range(7, 14)
				: $urandom_range(1, 6));
		end else if (pick < 78) begin
			send_aborted_run();
		end else begin
			// noise: any op code, random depth effect
			repeat ($urandom_range(1, 6)) begin
				send_token(3'($urandom_range(7)), pick_value());
			end
		end
	endtask

	// directed corners, starting from an empty stack
	task automatic send_directed();
		send_token(OP_FINISH, '0);                 // finish on empty stack
		send_token(OP_DIV, '0);                    // divide with nothing stacked
		send_token(OP_SUB, '0);                    // operator on empty, pushes 0
		send_token(OP_FINISH, '0);
		send_token(OP_PUSH, 32'sh7FFF_FFFF);
		send_token(OP_PUSH, 32'sh7FFF_FFFF);
		send_token(OP_ADD, '0);                    // sum saturates high
		send_token(OP_PUSH, 32'sh8000_0000);
		send_token(OP_SUB, '0);                    // difference saturates high
		send_token(OP_PUSH, 32'sh8000_0000);
		send_token(OP_MUL, '0);                    // product saturates low
		send_token(OP_PUSH, 32'shFFFF_FFFF);
		send_token(OP_PUSH, 32'sh0000_8000);
		send_token(OP_MUL, '0);                    // small negative product floors
		send_token(OP_PUSH, '0);
		send_token(OP_DIV, '1);                    // zero divisor
		send_token(OP_PUSH, 32'sh8000_0000);
		send_token(OP_PUSH, 32'shFFFF_FFFF);
		send_token(OP_DIV, '0);                    // quotient saturates high
		send_token(OP_PUSH, 32'shFFFD_0000);
		send_token(OP_DIV, '0);                    // negative quotient truncates
		send_token(OP_UNKNOWN, '0);
		send_token(OP_PUSH, 32'sh1234_5678);      // ignored while aborted
		send_token(OP_UNKNOWN_ALT, '0);            // ignored while aborted
		send_token(OP_FINISH, '0);                 // clears abort
		send_token(OP_UNKNOWN_ALT, '0);            // spare code acts as unknown
		send_token(OP_FINISH, '0);
	endtask

	// --------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------
	initial begin
		int goal;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();

		for (int ph = 0; ph < 4; ph++) begin
			// sender pause: every result beat in before the next phase
			drain_results();
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					// long hold-off while tokens keep coming: input backs up
					hold_left = 300;
				end
				1: begin
					send_idle_pct = 51;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 51;
					fill_and_drain();
				end
				default: begin
					send_idle_pct = 12;
					stall_pct = 12;
					hold_left = 200;
				end
			endcase
			goal = tokens_sent + 350;
			while (tokens_sent < goal) begin
				send_random_sequence();
			end
		end

		drain_results();
		// tail: catch stray beats, longer than a divide
		repeat (80) @(posedge clk);
		if (rpn_board.errors == 0 && rpn_board.expected_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== rpn_stack_evaluator_top.f =====
+incdir+sv
sv/rse_pkg.sv
sv/rse_stack_mem.sv
sv/rse_div.sv
sv/rse_arith.sv
sv/rpn_stack_evaluator_top.sv
sv/rse_checker.sv
tb/rpn_stack_evaluator_top_tb.sv
